>>> rtl/core/mwsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwsm_pkg: shared constants for the minimum window subsequence matcher
// Pattern table and fixed field widths of the stream words.
// ----------------------------------------------------------------------------
package mwsm_pkg;

   localparam int PatSlots  = 16;
   localparam int CharW     = 8;
   localparam int OutLenW   = 18;
   localparam int RspDataW  = 24;

   typedef logic [CharW-1:0] char_type;

   // pattern letters, unused slots hold zero
   localparam char_type PATTERN_TAB [PatSlots] = '{
      8'h70, 8'h75, 8'h6C, 8'h65, 8'h79, 8'h61, 8'h6B, 8'h6E,
      8'h6F, 8'h69, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   // result code when no window was found
   localparam logic [OutLenW-1:0] NoWindow = '1;

endpackage : mwsm_pkg
`default_nettype wire

>>> rtl/core/min_window_subsequence_matcher_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_window_subsequence_matcher_unit: shortest window holding a subsequence
// Streams a string one byte per word and reports, on the last byte, the
// length of the shortest substring containing the pattern as a subsequence.
// ----------------------------------------------------------------------------
// Path: the last input byte on req_tdata loads the input register, then the
//   result register on rsp_tdata once the result slot is free.
// Throughput: one byte per cycle, set by the single update pass over the
//   parallel prefix registers; a final byte waits for a free result slot.
// Reset: synchronous, active high; clears the string state and both valids.
//   No clearing pass is needed, the block is ready the cycle after reset.
module min_window_subsequence_matcher_unit
   import mwsm_pkg::*;
#(
   parameter longint unsigned MAX_LEN     = 65536,
   parameter int              PATTERN_LEN = 10
) (
   input  wire                 clock,
   input  wire                 reset,
   // input stream
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire [CharW-1:0]     req_tdata,   // [7:0] char_code
   input  wire                 req_tlast,   // end_of_string
   // result stream
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [17:0] shortest_len, [23:18] zero
   output logic                rsp_tuser    // [0] too_long
);

   // position counts up to MAX_LEN, byte index stops at MAX_LEN-1
   localparam int PosW = $clog2(MAX_LEN + 1);
   localparam int IdxW = $clog2(MAX_LEN);
   localparam int LenW = PosW;
   localparam int Top  = PATTERN_LEN - 1;
   localparam logic [PosW-1:0] MaxPos  = PosW'(MAX_LEN);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_LEN - 1);

   // ---------------------------------------------------------------- input reg
   logic             in_valid_ff;
   char_type         in_char_ff;
   logic             in_last_ff;
   logic             advance;

   // a non-final byte never needs the result slot; a final one waits for it
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // ------------------------------------------------------------- string state
   // prefix_start_ff[k]: latest start of a match of letters 0..k
   logic [IdxW-1:0]        prefix_start_ff [PATTERN_LEN];
   logic [IdxW-1:0]        prefix_start_in [PATTERN_LEN];
   logic [PATTERN_LEN-1:0] prefix_valid_ff;
   logic [PATTERN_LEN-1:0] prefix_valid_in;
   logic [PosW-1:0]        pos_ff;
   logic [LenW-1:0]        best_len_ff;
   logic                   best_valid_ff;
   logic                   overflow_ff;

   logic                   saturated;
   logic [IdxW-1:0]        idx;
   logic [LenW-1:0]        win_len;
   logic                   hit;
   logic                   better;
   logic                   fin_valid;
   logic [LenW-1:0]        fin_len;
   logic [LenW+OutLenW-1:0] fin_wide;

   // bytes past MAX_LEN all count as the last index
   assign saturated = (pos_ff >= MaxPos);
   assign idx       = saturated ? LastIdx : pos_ff[IdxW-1:0];

   // every prefix updates from the old values in parallel
   always_comb begin
      prefix_valid_in = prefix_valid_ff;
      for (int k = 0; k < PATTERN_LEN; k++) begin
         prefix_start_in[k] = prefix_start_ff[k];
         if (in_char_ff == PATTERN_TAB[k]) begin
            if (k == 0) begin
               prefix_start_in[k] = idx;
               prefix_valid_in[k] = 1'b1;
            end else if (prefix_valid_ff[(k == 0) ? 0 : k - 1]) begin
               prefix_start_in[k] = prefix_start_ff[(k == 0) ? 0 : k - 1];
               prefix_valid_in[k] = 1'b1;
            end
         end
      end
   end

   // a full match ends at this byte
   assign hit     = (in_char_ff == PATTERN_TAB[Top]) && prefix_valid_in[Top]
                    && (idx >= prefix_start_in[Top]);
   assign win_len = LenW'(idx) - LenW'(prefix_start_in[Top]) + LenW'(1);
   assign better  = hit && (!best_valid_ff || (win_len < best_len_ff));

   assign fin_valid = best_valid_ff || hit;
   assign fin_len   = better ? win_len : best_len_ff;
   assign fin_wide  = {{OutLenW{1'b0}}, fin_len};

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_valid_ff <= '0;
         pos_ff          <= '0;
         best_valid_ff   <= 1'b0;
         overflow_ff     <= 1'b0;
      end else if (advance) begin
         if (in_last_ff) begin
            // string done: start the next one clean
            prefix_valid_ff <= '0;
            pos_ff          <= '0;
            best_valid_ff   <= 1'b0;
            overflow_ff     <= 1'b0;
         end else begin
            prefix_valid_ff <= prefix_valid_in;
            if (saturated) begin
               overflow_ff <= 1'b1;
            end else begin
               pos_ff <= pos_ff + PosW'(1);
            end
            if (better) begin
               best_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prefix_start_ff <= prefix_start_in;
         if (better) begin
            best_len_ff <= win_len;
         end
      end
   end

   // --------------------------------------------------------------- result reg
   logic                      rsp_valid_ff;
   logic signed [OutLenW-1:0] rsp_len_ff;
   logic                      rsp_long_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_len_ff  <= fin_valid ? fin_wide[OutLenW-1:0] : NoWindow;
         rsp_long_ff <= overflow_ff || saturated;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW - OutLenW){1'b0}}, rsp_len_ff};
   assign rsp_tuser  = rsp_long_ff;

   // --------------------------------------------------------------- assertions
   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> rsp_valid_ff)
      else $error("final byte did not load a result");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= MaxPos)
      else $error("position beyond saturation point");

   a_overflow_saturated: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (pos_ff == MaxPos))
      else $error("overflow flagged while position not saturated");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      best_valid_ff |-> ((best_len_ff != '0) && (best_len_ff <= pos_ff)))
      else $error("best length outside the bytes seen");

   a_prefix_chain: assert property (@(posedge clock) disable iff (reset)
      ((prefix_valid_ff >> 1) & ~prefix_valid_ff) == '0)
      else $error("longer prefix valid without shorter one");

endmodule : min_window_subsequence_matcher_unit
`default_nettype wire
